// ----- sv/spq_pkg.sv -----
// shared types and constants for the sorted priority queue
package spq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_INSERTED    = 2'd0;
  localparam logic [1:0] STATUS_REMOVED     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY       = 2'd2;
  localparam logic [1:0] STATUS_FULL_REFUSE = 2'd3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] data_in;
    logic        [15:0] priority_in;
  } command_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic        [15:0] priority_out;
    logic        [1:0]  status;
    logic        [4:0]  occupancy;
  } result_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic        [15:0] rank;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t fresh;
  } cell_ctrl_t;

endpackage

// ----- sv/sorted_priority_queue_core.sv -----
// top level of the sorted priority queue built from a chain of cells
//
//   channel   signals                    transfer when
//   command   start, busy, command       start high and busy low
//   result    done, result               done high (one cycle, no stall)
//
// the result of each command appears on the next cycle
// all cells update in parallel from their neighbors, so busy stays low
// rst clears the entry count and done; cell contents are left as they are
// the receiver cannot stall, each result is shown for exactly one cycle
module sorted_priority_queue_core #(
  parameter int DEPTH = spq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::command_t command,
  output logic              done,
  output spq_pkg::result_t  result
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic                take;
  logic                full;
  logic                empty;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::result_t    result_next;
  logic [31:0]         count_wide;

  spq_pkg::entry_t cells [DEPTH];
  logic            gts   [DEPTH];

  assign busy  = 1'b0;
  assign take  = start && !busy;
  assign full  = count == CW'(DEPTH);
  assign empty = count == '0;

  assign ctrl = '{
    ins:   take && (command.kind == spq_pkg::KIND_INSERT) && !full,
    rem:   take && (command.kind == spq_pkg::KIND_REMOVE) && !empty,
    fresh: '{data: command.data_in, rank: command.priority_in}
  };

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::entry_t left_e;
      spq_pkg::entry_t right_e;
      logic            left_g;
      if (i == 0) begin : g_first
        assign left_e = '0;
        assign left_g = 1'b0;
      end else begin : g_mid
        assign left_e = cells[i-1];
        assign left_g = gts[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right_e = cells[i];
      end else begin : g_inner
        assign right_e = cells[i+1];
      end
      spq_cell #(
        .CW    (CW),
        .INDEX (i)
      ) u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .count   (count),
        .left    (left_e),
        .left_gt (left_g),
        .right   (right_e),
        .gt      (gts[i]),
        .entry   (cells[i])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + CW'(1);
    end else if (ctrl.rem) begin
      count_next = count - CW'(1);
    end
  end

  assign count_wide = 32'(count_next);

  always_comb begin
    result_next.data_out     = '0;
    result_next.priority_out = '0;
    result_next.occupancy    = count_wide[4:0];
    if (command.kind == spq_pkg::KIND_INSERT) begin
      result_next.status = full ? spq_pkg::STATUS_FULL_REFUSE : spq_pkg::STATUS_INSERTED;
    end else if (empty) begin
      result_next.status = spq_pkg::STATUS_EMPTY;
    end else begin
      result_next.status       = spq_pkg::STATUS_REMOVED;
      result_next.data_out     = cells[0].data;
      result_next.priority_out = cells[0].rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

endmodule

// ----- sv/spq_cell.sv -----
// one storage cell of the sorted priority queue chain
module spq_cell #(
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]     count,
  input  spq_pkg::entry_t   left,
  input  logic              left_gt,
  input  spq_pkg::entry_t   right,
  output logic              gt,
  output spq_pkg::entry_t   entry
);

  logic            valid;
  spq_pkg::entry_t entry_next;

  assign valid = CW'(INDEX) < count;
  assign gt    = (valid && (entry.rank > ctrl.fresh.rank)) || (count == CW'(INDEX));

  always_comb begin
    entry_next = entry;
    if (ctrl.ins && gt) begin
      entry_next = left_gt ? left : ctrl.fresh;
    end else if (ctrl.rem) begin
      entry_next = right;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- tb/sorted_priority_queue_core_test.sv -----
// testbench for the sorted priority queue core: directed and random traffic checked against a model
module sorted_priority_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = spq_pkg::DEPTH_DEFAULT;
  localparam int RANDOM_BURSTS = 25;
  localparam int BURST_LEN = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  spq_pkg::command_t command = '0;
  logic done;
  spq_pkg::result_t result;

  logic [31:0] model_data [QUEUE_DEPTH];
  logic [15:0] model_rank [QUEUE_DEPTH];
  int model_count = 0;

  spq_pkg::result_t pending_results [$];
  int mismatch_count = 0;
  int status_hits [4] = '{0, 0, 0, 0};
  bit idle_enabled = 1'b1;

  sorted_priority_queue_core #(.DEPTH(QUEUE_DEPTH)) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result)
  );

  always #4 clk = ~clk;

  function automatic spq_pkg::result_t apply_to_model(input spq_pkg::command_t c);
    spq_pkg::result_t r;
    int slot;
    r = '0;
    if (c.kind == spq_pkg::KIND_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.status = spq_pkg::STATUS_FULL_REFUSE;
      end else begin
        slot = model_count;
        while (slot > 0 && model_rank[slot-1] > c.priority_in) begin
          model_data[slot] = model_data[slot-1];
          model_rank[slot] = model_rank[slot-1];
          slot--;
        end
        model_data[slot] = c.data_in;
        model_rank[slot] = c.priority_in;
        model_count++;
        r.status = spq_pkg::STATUS_INSERTED;
      end
    end else begin
      if (model_count == 0) begin
        r.status = spq_pkg::STATUS_EMPTY;
      end else begin
        r.data_out = model_data[0];
        r.priority_out = model_rank[0];
        for (int i = 1; i < model_count; i++) begin
          model_data[i-1] = model_data[i];
          model_rank[i-1] = model_rank[i];
        end
        model_count--;
        r.status = spq_pkg::STATUS_REMOVED;
      end
    end
    r.occupancy = model_count[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input spq_pkg::result_t exp,
                                 input spq_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t mismatch (%s): exp data=%0d pri=%0d st=%0d occ=%0d, ",
               $realtime, what, exp.data_out, exp.priority_out, exp.status, exp.occupancy,
               "got data=%0d pri=%0d st=%0d occ=%0d",
               got.data_out, got.priority_out, got.status, got.occupancy);
    end
  endtask

  always @(posedge clk) begin : monitor
    spq_pkg::result_t expected;
    if (!rst) begin
      if (done === 1'b1) begin
        if (pending_results.size() == 0) begin
          report_mismatch("no transfer pending", '0, result);
        end else begin
          expected = pending_results.pop_front();
          if ((result.data_out !== expected.data_out) ||
              (result.priority_out !== expected.priority_out) ||
              (result.status !== expected.status) ||
              (result.occupancy !== expected.occupancy)) begin
            report_mismatch("wrong field", expected, result);
          end
        end
      end
      if (start && !busy) begin
        expected = apply_to_model(command);
        status_hits[expected.status]++;
        pending_results.push_back(expected);
      end
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (!idle_enabled || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic spq_pkg::command_t make_command(input logic k, input logic [31:0] d,
                                                     input logic [15:0] p);
    spq_pkg::command_t c;
    c.kind = k;
    c.data_in = d;
    c.priority_in = p;
    return c;
  endfunction

  task automatic send_command(input spq_pkg::command_t c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    command <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic test_remove_on_empty();
    send_command(make_command(spq_pkg::KIND_REMOVE, 32'h7FFF_FFFF, 16'hFFFF));
  endtask

  task automatic test_fill_to_refusal();
    logic [15:0] pri_list [16] = '{16'hFFFF, 16'h0000, 16'h0005, 16'h0005,
                                   16'h8000, 16'h0000, 16'hFFFF, 16'h0005,
                                   16'h0001, 16'h7FFF, 16'h5555, 16'hAAAA,
                                   16'h0005, 16'hFFFE, 16'h0000, 16'h8000};
    logic [31:0] dat_list [16] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                                   32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0001, 32'h8000_0001,
                                   32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                                   32'h7FFF_FFFE, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0002};
    for (int i = 0; i < 16; i++) begin
      send_command(make_command(spq_pkg::KIND_INSERT, dat_list[i], pri_list[i]));
    end
    send_command(make_command(spq_pkg::KIND_INSERT, 32'h8000_0000, 16'h0000));
  endtask

  task automatic test_partial_drain();
    for (int i = 0; i < 4; i++) begin
      send_command(make_command(spq_pkg::KIND_REMOVE, $urandom,
                                16'($urandom_range(0, 65535))));
    end
  endtask

  task automatic test_random_traffic();
    int insert_pct;
    int rank_mode;
    int base;
    logic [15:0] p;
    logic k;
    for (int b = 0; b < RANDOM_BURSTS; b++) begin
      case ($urandom_range(0, 3))
        0: insert_pct = 20;
        1: insert_pct = 50;
        2: insert_pct = 80;
        default: insert_pct = 95;
      endcase
      rank_mode = $urandom_range(0, 3);
      base = $urandom_range(0, 65535 - 8);
      idle_enabled = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < BURST_LEN; n++) begin
        k = ($urandom_range(0, 99) < insert_pct) ? spq_pkg::KIND_INSERT : spq_pkg::KIND_REMOVE;
        case (rank_mode)
          0: p = 16'($urandom_range(0, 65535));
          1: p = 16'($urandom_range(0, 3));
          2: begin
            case ($urandom_range(0, 3))
              0: p = 16'h0000;
              1: p = 16'h0001;
              2: p = 16'hFFFE;
              default: p = 16'hFFFF;
            endcase
          end
          default: p = 16'(base + int'($urandom_range(0, 8)));
        endcase
        send_command(make_command(k, $urandom, p));
      end
      if (b % 5 == 4) wait_for_drain();
    end
    idle_enabled = 1'b1;
  endtask

  initial begin : main
    int leftover;
    int waited;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_remove_on_empty();
    test_fill_to_refusal();
    test_partial_drain();
    wait_for_drain();
    test_random_traffic();
    start <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (pending_results.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    repeat (5) @(posedge clk);
    leftover = pending_results.size();
    if (leftover != 0) $display("%0d expected results never arrived", leftover);
    $display("covered %0d inserts, %0d removes, %0d removes on empty, %0d refused inserts",
             status_hits[spq_pkg::STATUS_INSERTED], status_hits[spq_pkg::STATUS_REMOVED],
             status_hits[spq_pkg::STATUS_EMPTY], status_hits[spq_pkg::STATUS_FULL_REFUSE]);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0 && leftover == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
